>>> rtl/core/point_grid_occupancy_counter_top_macros.svh
// Assertion macros for the point grid occupancy counter.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef POINT_GRID_OCCUPANCY_COUNTER_TOP_MACROS_SVH
`define POINT_GRID_OCCUPANCY_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PGOC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgoc: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define PGOC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgoc: next-cycle check failed");
`else
`define PGOC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PGOC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/pgoc_pkg.sv
// Shared types and constants for the point grid occupancy counter.
// No dependencies; imported by every module of the block.
package pgoc_pkg;

  localparam int COORD_W    = 20;  // point coordinate, signed, 8 fraction bits
  localparam int CS_W       = 16;  // cell size register
  localparam int HE_W       = 19;  // half extent register
  localparam int COUNT_W    = 16;  // per-cell count
  localparam int OCC_W      = 17;  // occupied cell total
  localparam int OUT_IDX_W  = 8;   // reported row / column
  localparam int CFG_DATA_W = 19;  // widest config register
  localparam int CFG_IDX_W  = 1;

  localparam logic [CS_W-1:0]    CELL_SIZE_RST   = 16'd256;
  localparam logic [HE_W-1:0]    HALF_EXTENT_RST = 19'd25600;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [OCC_W-1:0]   OCC_MAX         = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ADD   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_FETCH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_DIVX,
    S_DIVY_GO,
    S_DIVY,
    S_AIDX,
    S_ARD,
    S_AWR,
    S_FSCAN
  } state_t;

endpackage

>>> rtl/core/point_grid_occupancy_counter_top.sv
// Top level of the point grid occupancy counter: sequencer, cursor and results.
// Depends on pgoc_pkg, pgoc_div, pgoc_mem and the assertion macro header.

// Point grid occupancy counter. Issue one command per transfer: raise start
// with kind, point_x and point_y while busy is low; the command is taken at
// that clock edge and busy rises until it finishes. Every command returns
// exactly one result, shown on the result ports for a single cycle with done
// high; there is no back-pressure, so capture it in that cycle. Busy drops in
// the result cycle. Timing is set by the single shared divider and the count
// memory with one read and one write port; per command:
//   add   : two 20-step divisions for row and column, then one read-modify-
//           write of the cell count; a point off the canvas returns from the
//           canvas check, one beyond the grid side after both divisions,
//           with no memory write;
//   fetch : reads the cells from the walk cursor up to and including the next
//           occupied one, or up to the grid end, one memory read per cycle;
//   clear : zeroes all GRID_SIDE*GRID_SIDE cells, one memory word a cycle;
//   kind 3: no state change, and busy stays low.
// After reset the same clearing pass runs first (busy high, no result).
// Configuration writes take effect at the edge where cfg_write is high and
// belong in idle periods.
`include "point_grid_occupancy_counter_top_macros.svh"

module point_grid_occupancy_counter_top
  import pgoc_pkg::*;
#(
  parameter int GRID_SIDE = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            kind,
  input  logic signed [COORD_W-1:0] point_x,
  input  logic signed [COORD_W-1:0] point_y,
  // configuration write port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result channel
  output logic                  done,
  output logic                  in_range,
  output logic [OUT_IDX_W-1:0]  cell_row,
  output logic [OUT_IDX_W-1:0]  cell_col,
  output logic [COUNT_W-1:0]    cell_count,
  output logic [OCC_W-1:0]      occupied_cells,
  output logic                  walk_done
);

  localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW    = $clog2(CELL_TOTAL);
  localparam int RW         = $clog2(GRID_SIDE);
  localparam logic [CELL_AW-1:0] LAST_IDX = CELL_AW'(CELL_TOTAL - 1);
  localparam logic [RW-1:0]      LAST_ROW = RW'(GRID_SIDE - 1);

  state_t state, state_next;

  // configuration
  logic [CS_W-1:0] cell_size;
  logic [HE_W-1:0] half_extent;

  // command capture
  kind_t                     kind_q;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;

  // running state
  logic [OCC_W-1:0]   occ_total;
  logic [CELL_AW-1:0] cur_idx;
  logic [RW-1:0]      cur_row;
  logic [RW-1:0]      cur_col;

  // clearing sweep
  logic [CELL_AW-1:0] clr_idx;
  logic               clr_item;

  // add path
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic [CELL_AW-1:0] idx_q;

  // fetch scan: issue pointer and pointer of the data coming back
  logic [CELL_AW-1:0] scan_idx;
  logic [RW-1:0]      scan_row;
  logic [RW-1:0]      scan_col;
  logic [CELL_AW-1:0] d_idx;
  logic [RW-1:0]      d_row;
  logic [RW-1:0]      d_col;
  logic               d_last;

  // shared divider and memory
  logic               div_start;
  logic [COORD_W-1:0] div_dividend;
  logic [CS_W-1:0]    div_divisor;
  logic               div_done;
  logic [COORD_W-1:0] div_quo;

  logic               mem_we;
  logic [CELL_AW-1:0] mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic [CELL_AW-1:0] mem_raddr;
  logic [COUNT_W-1:0] mem_rdata;

  logic               accept;
  logic               done_next;
  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic               pt_ok;
  logic [COORD_W-1:0] sum_x;
  logic [COORD_W-1:0] sum_y;
  logic               bin_ok;
  logic [COUNT_W-1:0] cnt_inc;
  logic               cnt_zero;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Magnitudes; the most negative code maps to its true magnitude as unsigned.
  assign ax    = px[COORD_W-1] ? COORD_W'(-px) : COORD_W'(px);
  assign ay    = py[COORD_W-1] ? COORD_W'(-py) : COORD_W'(py);
  assign pt_ok = (ax < COORD_W'(half_extent)) && (ay < COORD_W'(half_extent));

  // Inside the canvas the shifted coordinate is positive and below 2^20.
  assign sum_x = COORD_W'({px[COORD_W-1], px} + {2'b00, half_extent});
  assign sum_y = COORD_W'({py[COORD_W-1], py} + {2'b00, half_extent});

  assign bin_ok   = (row_q < COORD_W'(GRID_SIDE)) && (col_q < COORD_W'(GRID_SIDE));
  assign cnt_zero = (mem_rdata == '0);
  assign cnt_inc  = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1;
  assign d_last   = (d_idx == LAST_IDX);

  pgoc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  pgoc_mem #(
    .DEPTH (CELL_TOTAL),
    .AW    (CELL_AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_ADD:   state_next = S_ACHK;
            KIND_CLEAR: state_next = S_CLEAR;
            KIND_FETCH: state_next = S_FSCAN;
            KIND_NONE:  state_next = S_IDLE;
          endcase
        end
      end
      S_ACHK:    state_next = pt_ok ? S_DIVX : S_IDLE;
      S_DIVX:    if (div_done) state_next = S_DIVY_GO;
      S_DIVY_GO: state_next = S_DIVY;
      S_DIVY:    if (div_done) state_next = S_AIDX;
      S_AIDX:    state_next = bin_ok ? S_ARD : S_IDLE;
      S_ARD:     state_next = S_AWR;
      S_AWR:     state_next = S_IDLE;
      S_FSCAN: begin
        if (!cnt_zero || d_last) state_next = S_IDLE;
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // Divider, memory and result strobe controls
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_x;
    div_divisor  = (cell_size == '0) ? CS_W'(1) : cell_size;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = cnt_inc;
    mem_raddr    = idx_q;
    done_next    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        done_next = clr_item && (clr_idx == LAST_IDX);
      end
      S_IDLE: begin
        mem_raddr = cur_idx;  // first fetch read goes out on accept
        done_next = accept && (kind_t'(kind) == KIND_NONE);
      end
      S_ACHK: begin
        div_start = pt_ok;
        done_next = !pt_ok;
      end
      S_DIVY_GO: begin
        div_start    = 1'b1;
        div_dividend = sum_y;
      end
      S_AIDX:    done_next = !bin_ok;
      S_AWR: begin
        mem_we    = 1'b1;
        done_next = 1'b1;
      end
      S_FSCAN: begin
        mem_raddr = scan_idx;
        done_next = !cnt_zero || d_last;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size   <= CELL_SIZE_RST;
      half_extent <= HALF_EXTENT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CELL_SIZE:   cell_size   <= cfg_data[CS_W-1:0];
        CFG_HALF_EXTENT: half_extent <= cfg_data[HE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state: sequencer, totals, cursor, sweep, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      clr_item  <= 1'b0;
      occ_total <= '0;
      cur_idx   <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == LAST_IDX) begin
            clr_idx  <= '0;
            clr_item <= 1'b0;
          end else begin
            clr_idx <= clr_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept && kind_t'(kind) == KIND_CLEAR) begin
            // drop totals and cursor now, zero the store over the sweep
            occ_total <= '0;
            cur_idx   <= '0;
            cur_row   <= '0;
            cur_col   <= '0;
            clr_idx   <= '0;
            clr_item  <= 1'b1;
          end
        end
        S_AWR: begin
          if (cnt_zero && occ_total != OCC_MAX) occ_total <= occ_total + 1'b1;
        end
        S_FSCAN: begin
          if (!cnt_zero || d_last) begin
            // advance the cursor just past the cell found, wrap at grid end
            cur_idx <= d_last ? '0 : scan_idx;
            cur_row <= d_last ? '0 : scan_row;
            cur_col <= d_last ? '0 : scan_col;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          kind_q <= kind_t'(kind);
          px     <= point_x;
          py     <= point_y;
          // first fetch read is in flight for the cursor cell
          d_idx  <= cur_idx;
          d_row  <= cur_row;
          d_col  <= cur_col;
          scan_idx <= cur_idx + 1'b1;
          scan_row <= (cur_row == LAST_ROW) ? '0 : cur_row + 1'b1;
          scan_col <= (cur_row == LAST_ROW) ? cur_col + 1'b1 : cur_col;
          in_range       <= 1'b0;
          cell_row       <= '0;
          cell_col       <= '0;
          cell_count     <= '0;
          occupied_cells <= occ_total;
          walk_done      <= 1'b0;
        end
      end
      S_CLEAR: begin
        in_range       <= 1'b0;
        cell_row       <= '0;
        cell_col       <= '0;
        cell_count     <= '0;
        occupied_cells <= '0;
        walk_done      <= 1'b0;
      end
      S_DIVX: if (div_done) row_q <= div_quo;
      S_DIVY: if (div_done) col_q <= div_quo;
      S_AIDX: begin
        idx_q <= CELL_AW'(col_q[RW-1:0]) * CELL_AW'(GRID_SIDE) + CELL_AW'(row_q[RW-1:0]);
      end
      S_AWR: begin
        in_range       <= 1'b1;
        cell_row       <= OUT_IDX_W'(row_q[RW-1:0]);
        cell_col       <= OUT_IDX_W'(col_q[RW-1:0]);
        cell_count     <= cnt_inc;
        occupied_cells <= (cnt_zero && occ_total != OCC_MAX) ? occ_total + 1'b1
                                                             : occ_total;
      end
      S_FSCAN: begin
        // hold one read in flight: the data now back belongs to d_*
        d_idx    <= scan_idx;
        d_row    <= scan_row;
        d_col    <= scan_col;
        scan_idx <= scan_idx + 1'b1;
        scan_row <= (scan_row == LAST_ROW) ? '0 : scan_row + 1'b1;
        scan_col <= (scan_row == LAST_ROW) ? scan_col + 1'b1 : scan_col;
        if (!cnt_zero) begin
          in_range   <= 1'b1;
          cell_row   <= OUT_IDX_W'(d_row);
          cell_col   <= OUT_IDX_W'(d_col);
          cell_count <= mem_rdata;
          walk_done  <= d_last;
        end else if (d_last) begin
          walk_done  <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  `PGOC_ASSERT_IMP(a_done_when_idle, clk, rst, done, !busy)
  `PGOC_ASSERT_IMP(a_hit_nonzero, clk, rst, done && in_range,
                   cell_count != '0 && occupied_cells != '0)
  `PGOC_ASSERT_IMP(a_walk_end_cell, clk, rst, done && in_range && walk_done,
                   cell_row == OUT_IDX_W'(GRID_SIDE - 1) &&
                   cell_col == OUT_IDX_W'(GRID_SIDE - 1))
  `PGOC_ASSERT_IMP(a_div_add_only, clk, rst, div_start, kind_q == KIND_ADD)
  `PGOC_ASSERT_NXT(a_take_goes_busy, clk, rst, accept && kind != KIND_NONE, busy)

endmodule

>>> rtl/core/pgoc_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pgoc_pkg for operand widths.
module pgoc_div
  import pgoc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [COORD_W-1:0] dividend,
  input  logic [CS_W-1:0]    divisor,
  output logic               done,
  output logic [COORD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [CS_W-1:0]    rem;
  logic [CS_W-1:0]    dvs;
  logic [COORD_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               run;

  logic [CS_W:0]      rem_sh;
  logic [CS_W:0]      trial;
  logic               ge;

  assign rem_sh   = {rem, quo[COORD_W-1]};
  assign trial    = rem_sh - {1'b0, dvs};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == CNT_W'(1));
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(COORD_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Datapath: load operands on start, shift one bit per step.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (run) begin
      rem <= ge ? trial[CS_W-1:0] : rem_sh[CS_W-1:0];
      quo <= {quo[COORD_W-2:0], ge};
    end
  end

endmodule

>>> rtl/core/pgoc_mem.sv
// Cell count store: one write port, one read port with registered data.
// Depends on pgoc_pkg for the count width.
module pgoc_mem
  import pgoc_pkg::*;
#(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [COUNT_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [COUNT_W-1:0] rdata
);

  logic [COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> verif/point_grid_occupancy_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_grid_occupancy_counter_top.
// Depends on pgoc_pkg and the block RTL; runs directed grid walks, then random phases.

module testbench;
  import pgoc_pkg::*;

  localparam int GRID        = 256;
  localparam int CELLS       = GRID * GRID;
  localparam int CYCLE_LIMIT = 8_000_000;  // clears and full walks each sweep all 64K cells

  // One result of the block, field by field.
  typedef struct packed {
    logic                 in_range;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic [COUNT_W-1:0]   count;
    logic [OCC_W-1:0]     occ;
    logic                 walk_done;
  } cell_report_t;

  // Clock and reset
  logic clk;
  logic rst = 1'b1;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Block ports; every input starts at a known value
  logic                         start     = 1'b0;
  logic                         busy;
  logic [1:0]                   kind      = KIND_ADD;
  logic signed [COORD_W-1:0]    point_x   = '0;
  logic signed [COORD_W-1:0]    point_y   = '0;
  logic                         cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data  = '0;
  logic                         done;
  logic                         in_range;
  logic [OUT_IDX_W-1:0]         cell_row;
  logic [OUT_IDX_W-1:0]         cell_col;
  logic [COUNT_W-1:0]           cell_count;
  logic [OCC_W-1:0]             occupied_cells;
  logic                         walk_done;

  point_grid_occupancy_counter_top #(
    .GRID_SIDE(GRID)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .kind          (kind),
    .point_x       (point_x),
    .point_y       (point_y),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .in_range      (in_range),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .cell_count    (cell_count),
    .occupied_cells(occupied_cells),
    .walk_done     (walk_done)
  );

  // Shadow of the grid: counts, occupancy, walk cursor and the two registers
  bit   [COUNT_W-1:0] tally [0:CELLS-1];
  logic [OCC_W-1:0]   occupied        = '0;
  int unsigned        walk_cursor     = 0;
  logic [CS_W-1:0]    cell_size_cfg   = CELL_SIZE_RST;
  logic [HE_W-1:0]    half_extent_cfg = HALF_EXTENT_RST;

  cell_report_t pending_reports[$];  // results owed by the block, oldest first
  int  fail_count  = 0;
  int  cycle_count = 0;
  bit  gaps_on     = 1'b1;          // sender idles at random when set
  int  walk_wraps  = 0;             // walks that reached the grid end in this phase

  // Recently used points, reused so that cells collect more than one hit
  logic signed [COORD_W-1:0] hot_x [0:7];
  logic signed [COORD_W-1:0] hot_y [0:7];

  // Apply one command to the shadow grid and return the result it must produce.
  task automatic step_grid(input kind_t k, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y, output cell_report_t rep);
    longint      px, py, he, cs, row, col;
    int unsigned slot;
    bit          found;
    rep     = '0;
    rep.occ = occupied;
    slot    = 0;
    found   = 1'b0;
    case (k)
      KIND_ADD: begin
        px = longint'(x);
        py = longint'(y);
        he = longint'(half_extent_cfg);
        cs = longint'(cell_size_cfg);
        if (cs == 0) begin
          cs = 1;  // a zero cell size bins as one
        end
        // Count only points strictly inside the canvas and inside the grid side
        if (px < he && -px < he && py < he && -py < he) begin
          row = (px + he) / cs;
          col = (py + he) / cs;
          if (row < GRID && col < GRID) begin
            slot = int'(col * GRID + row);
            if (tally[slot] == 0 && occupied < OCC_MAX) begin
              occupied++;
            end
            if (tally[slot] != COUNT_MAX) begin
              tally[slot]++;
            end
            rep.in_range = 1'b1;
            rep.row      = row[OUT_IDX_W-1:0];
            rep.col      = col[OUT_IDX_W-1:0];
            rep.count    = tally[slot];
            rep.occ      = occupied;
          end
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          tally[i] = '0;
        end
        occupied    = '0;
        walk_cursor = 0;
        rep         = '0;
      end
      KIND_FETCH: begin
        // Walk column-major from the cursor to the next nonempty cell
        for (int i = walk_cursor; i < CELLS && !found; i++) begin
          if (tally[i] != 0) begin
            found = 1'b1;
            slot  = i;
          end
        end
        if (found) begin
          rep.in_range  = 1'b1;
          rep.row       = OUT_IDX_W'(slot % GRID);
          rep.col       = OUT_IDX_W'(slot / GRID);
          rep.count     = tally[slot];
          rep.walk_done = (slot == CELLS - 1);
          walk_cursor   = rep.walk_done ? 0 : slot + 1;
        end else begin
          rep.walk_done = 1'b1;
          walk_cursor   = 0;
        end
      end
      default: begin
        // Unused kind: nothing moves, only the occupancy is reported
      end
    endcase
  endtask

  // Issue one command. Raise start at a falling edge and hold it until busy
  // is low, so the transfer lands on the next rising edge. Leave start high
  // on return: the next call lowers it or reuses it at the following falling
  // edge, which is always before busy can drop again.
  task automatic send_item(input kind_t k, input logic signed [COORD_W-1:0] x,
                           input logic signed [COORD_W-1:0] y);
    cell_report_t rep;
    @(negedge clk);
    // Now and then let the block go idle before the next command shows up
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      @(negedge clk);
      while (busy) @(negedge clk);
    end
    while (gaps_on && $urandom_range(0, 99) < 19) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    kind    <= k;
    point_x <= x;
    point_y <= y;
    // busy only moves on rising edges, so its value here holds at the next one
    while (busy) @(negedge clk);
    step_grid(k, x, y, rep);
    pending_reports.insert(pending_reports.size(), rep);
    if (k == KIND_FETCH && rep.walk_done) begin
      walk_wraps++;
    end
    @(posedge clk);
  endtask

  // Drop start and wait until every owed result has arrived and the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (pending_reports.size() == 0);
    @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  // Write one register while the block is idle; mirror it in the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_CELL_SIZE) begin
      cell_size_cfg = value[CS_W-1:0];
    end else begin
      half_extent_cfg = value[HE_W-1:0];
    end
  endtask

  // Uniform coordinate strictly inside the canvas of the given half extent.
  function automatic logic signed [COORD_W-1:0] canvas_coord(input logic [HE_W-1:0] he);
    int span;
    int v;
    span = (he == 0) ? 1 : int'(he);
    v    = int'($urandom_range(0, 2 * span - 2)) - (span - 1);
    return v[COORD_W-1:0];
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Take each result in the cycle its strobe is high and match it against the
  // oldest owed result.
  always @(posedge clk) begin
    cell_report_t want;
    if (!rst && done) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ns: result with none owed, expected nothing, got row %0d col %0d",
                 $time, cell_row, cell_col);
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("in_range", want.in_range, in_range);
        check_field("cell_row", want.row, cell_row);
        check_field("cell_col", want.col, cell_col);
        check_field("cell_count", want.count, cell_count);
        check_field("occupied_cells", want.occ, occupied_cells);
        check_field("walk_done", want.walk_done, walk_done);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Reset values: walk an empty grid, then fill corners and the center and
  // walk them in order, ending with a walk that runs off the end.
  task automatic test_walk_default_grid();
    send_item(KIND_FETCH, '0, '0);
    send_item(KIND_NONE, '0, '0);
    send_item(KIND_ADD, -20'sd25599, -20'sd25599);
    send_item(KIND_ADD, 20'sd0, 20'sd0);
    send_item(KIND_ADD, 20'sd25599, 20'sd25599);
    send_item(KIND_ADD, 20'sd25600, 20'sd0);          // on the canvas edge: dropped
    send_item(KIND_ADD, -20'sd524288, 20'sd524287);   // coordinate extremes
    send_item(KIND_ADD, 20'sd524287, -20'sd524288);
    send_item(KIND_ADD, 20'sd0, 20'sd0);
    repeat (4) send_item(KIND_FETCH, '0, '0);
    drain();
  endtask

  // Finest cells on the widest canvas: most of it lies beyond the grid side.
  // Walk down to the very last cell, which closes the walk with a hit.
  task automatic test_grid_edges();
    write_reg(CFG_CELL_SIZE, 19'd1);
    write_reg(CFG_HALF_EXTENT, 19'h7FFFF);
    send_item(KIND_ADD, 20'sd0, 20'sd0);
    send_item(KIND_ADD, -20'sd524286, -20'sd524032);
    send_item(KIND_ADD, -20'sd524032, -20'sd524032);
    repeat (5) send_item(KIND_FETCH, '0, '0);
    drain();
  endtask

  // Cell size zero bins as one; a half extent of one leaves only the origin.
  task automatic test_zero_cell_size();
    write_reg(CFG_CELL_SIZE, 19'd0);
    write_reg(CFG_HALF_EXTENT, 19'd1);
    send_item(KIND_ADD, 20'sd0, 20'sd0);
    send_item(KIND_ADD, 20'sd1, 20'sd0);
    send_item(KIND_ADD, -20'sd1, -20'sd1);
    drain();
  endtask

  task automatic test_clear();
    send_item(KIND_CLEAR, 20'hFFFFF, 20'hFFFFF);
    send_item(KIND_NONE, 20'hAAAAA, 20'h55555);
    drain();
  endtask

  // One register setting and a run of random commands. Keep at most one clear
  // and one walk off the grid end per phase: each costs a full memory pass.
  task automatic run_random_phase(input logic [CS_W-1:0] cs, input logic [HE_W-1:0] he,
                                  input int n_items, input bit with_gaps);
    int                        r;
    int                        slot;
    bit                        cleared;
    kind_t                     k;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    write_reg(CFG_CELL_SIZE, CFG_DATA_W'(cs));
    write_reg(CFG_HALF_EXTENT, he);
    gaps_on    = with_gaps;
    walk_wraps = 0;
    cleared    = 1'b0;
    for (int n = 0; n < n_items; n++) begin
      r    = $urandom_range(0, 999);
      slot = $urandom_range(0, 7);
      k    = KIND_ADD;
      x    = canvas_coord(he);
      y    = canvas_coord(he);
      if (r < 40) begin
        k = KIND_NONE;
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else if (r < 100) begin
        x = COORD_W'($urandom);  // anywhere, mostly off the canvas unless it spans the full range
        y = COORD_W'($urandom);
      end else if (r < 220 && walk_wraps == 0) begin
        k = KIND_FETCH;
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else if (r >= 995 && !cleared) begin
        k       = KIND_CLEAR;
        cleared = 1'b1;
      end else if (r < 520) begin
        x = hot_x[slot];
        y = hot_y[slot];
      end else begin
        hot_x[slot] = x;
        hot_y[slot] = y;
      end
      send_item(k, x, y);
    end
    drain();
  endtask

  initial begin
    logic [CS_W-1:0] rand_cs;
    logic [HE_W-1:0] rand_he;
    for (int i = 0; i < 8; i++) begin
      hot_x[i] = '0;
      hot_y[i] = '0;
    end
    // Hold reset, then release it at a falling edge; the block then clears its memory on its own
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_walk_default_grid();
    test_grid_edges();
    test_zero_cell_size();
    test_clear();

    run_random_phase(CELL_SIZE_RST, HALF_EXTENT_RST, 300, 1'b1);
    run_random_phase(16'd1, 19'd128, 300, 1'b0);  // canvas covers grid cells 1 to 255 on each axis, back to back
    run_random_phase(16'hFFFF, 19'h7FFFF, 250, 1'b1);
    run_random_phase(16'd0, 19'd1, 50, 1'b1);
    rand_cs = CS_W'($urandom_range(0, 65535) >> $urandom_range(0, 12));
    rand_he = HE_W'($urandom_range(1, 524287) >> $urandom_range(0, 10));
    if (rand_he == 0) begin
      rand_he = HE_W'(1);
    end
    run_random_phase(rand_cs, rand_he, 400, 1'b1);

    // Leave room for a stray late result
    repeat (64) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/pgoc_pkg.sv
rtl/core/pgoc_div.sv
rtl/core/pgoc_mem.sv
rtl/core/point_grid_occupancy_counter_top.sv
verif/point_grid_occupancy_counter_tb.sv
